// File: src/pbmc_pkg.sv
package pbmc_pkg;

   localparam int NUM_BUTTONS = 11;

   // button indexes
   localparam logic [3:0] BTN_RATE  = 4'd3;
   localparam logic [3:0] BTN_POWER = 4'd6;
   localparam logic [3:0] BTN_ALARM = 4'd7;
   localparam logic [3:0] BTN_PLAT  = 4'd8;
   localparam logic [3:0] BTN_DOWN  = 4'd9;
   localparam logic [3:0] BTN_UP    = 4'd10;
   localparam logic [3:0] BTN_NONE  = 4'd11;

   // mode codes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_HOLD    = 3'd1;
   localparam logic [2:0] MODE_WR_MOD  = 3'd2;
   localparam logic [2:0] MODE_WR_PTM  = 3'd3;
   localparam logic [2:0] MODE_WR_IDLE = 3'd4;
   localparam logic [2:0] MODE_MOD     = 3'd5;
   localparam logic [2:0] MODE_PTM     = 3'd6;
   localparam logic [2:0] MODE_DONE    = 3'd7;

   // button kinds
   localparam logic [1:0] KIND_TOGGLE  = 2'd0;
   localparam logic [1:0] KIND_TOGHOLD = 2'd1;
   localparam logic [1:0] KIND_MOMENT  = 2'd2;
   localparam logic [1:0] KIND_HOLD    = 2'd3;

   // adjust key codes
   localparam logic [1:0] ADJ_NONE = 2'd0;
   localparam logic [1:0] ADJ_UP   = 2'd1;
   localparam logic [1:0] ADJ_DOWN = 2'd2;

   // sound cues
   localparam logic [1:0] SND_NONE   = 2'd0;
   localparam logic [1:0] SND_BEEP   = 2'd1;
   localparam logic [1:0] SND_DOUBLE = 2'd2;
   localparam logic [1:0] SND_TONE   = 2'd3;

   // power states and requests
   localparam logic [1:0] PWR_OFF     = 2'd0;
   localparam logic [1:0] PWR_ON      = 2'd2;
   localparam logic [1:0] PREQ_NONE   = 2'd0;
   localparam logic [1:0] PREQ_UP     = 2'd1;
   localparam logic [1:0] PREQ_OFF    = 2'd2;

   // alarm actions
   localparam logic [1:0] ALARM_NONE = 2'd0;
   localparam logic [1:0] ALARM_MUTE = 2'd1;
   localparam logic [1:0] ALARM_WIPE = 2'd2;

   // register indexes
   localparam logic [2:0] REG_BUTTON_KINDS  = 3'd0;
   localparam logic [2:0] REG_RATE_HOLD     = 3'd1;
   localparam logic [2:0] REG_POWER_HOLD    = 3'd2;
   localparam logic [2:0] REG_ALARM_HOLD    = 3'd3;
   localparam logic [2:0] REG_EDIT_TIMEOUT  = 3'd4;

   localparam logic [21:0] RST_BUTTON_KINDS = 22'd2773056;
   localparam logic [15:0] RST_RATE_HOLD    = 16'd20;
   localparam logic [15:0] RST_POWER_HOLD   = 16'd60;
   localparam logic [15:0] RST_ALARM_HOLD   = 16'd60;
   localparam logic [15:0] RST_EDIT_TIMEOUT = 16'd300;

   typedef logic [NUM_BUTTONS-1:0][2:0] mode_vec_type;

   typedef struct packed {
      logic [21:0] button_kinds;
      logic [15:0] rate_hold_ticks;
      logic [15:0] power_hold_ticks;
      logic [15:0] alarm_hold_ticks;
      logic [15:0] edit_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0] sound_cue;
      logic [1:0] power_request;
      logic [1:0] alarm_action;
      logic       plateau_request;
      logic [1:0] adjust_event;
      logic [3:0] active_button;
      logic [2:0] active_mode;
      logic       fault;
   } rsp_type;

endpackage

// File: src/pbmc_step.sv
module pbmc_step #(
   parameter int TICK_WIDTH = 16
) (
   input  logic [pbmc_pkg::NUM_BUTTONS-1:0] pressed_i,
   input  logic [1:0]                       power_state_i,
   input  pbmc_pkg::cfg_type                cfg_i,
   input  pbmc_pkg::mode_vec_type           mode_i,
   input  logic [2:0][TICK_WIDTH-1:0]       count_i,
   input  logic [3:0]                       cur_btn_i,
   input  logic [1:0]                       cur_adj_i,
   input  logic [TICK_WIDTH-1:0]            idle_i,
   output pbmc_pkg::mode_vec_type           mode_o,
   output logic [2:0][TICK_WIDTH-1:0]       count_o,
   output logic [3:0]                       cur_btn_o,
   output logic [1:0]                       cur_adj_o,
   output logic [TICK_WIDTH-1:0]            idle_o,
   output pbmc_pkg::rsp_type                rsp_o
);
   import pbmc_pkg::*;

   localparam int CMP_W = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

   mode_vec_type              mode_v;
   logic [2:0][TICK_WIDTH-1:0] cnt_v;
   logic [3:0]                cur_v;
   logic [1:0]                adj_v;
   logic [TICK_WIDTH-1:0]     idle_v;
   logic [1:0]                snd_v;
   logic                      flt_v;
   logic [1:0]                preq_v;
   logic [1:0]                alarm_v;
   logic                      plat_v;
   logic [1:0]                adjevt_v;
   logic [3:0]                b_v;
   logic                      found_v;
   logic [3:0]                key_v;
   logic [1:0]                kind_v;
   logic [1:0]                slot_v;
   logic                      has_slot_v;
   logic                      reached_v;
   logic                      timeout_v;

   assign timeout_v = CMP_W'(idle_i) >= CMP_W'(cfg_i.edit_timeout_ticks);

   always_comb begin
      mode_v     = mode_i;
      cnt_v      = count_i;
      cur_v      = cur_btn_i;
      adj_v      = cur_adj_i;
      idle_v     = idle_i;
      snd_v      = SND_NONE;
      flt_v      = 1'b0;
      preq_v     = PREQ_NONE;
      alarm_v    = ALARM_NONE;
      plat_v     = 1'b0;
      adjevt_v   = ADJ_NONE;
      b_v        = 4'd0;
      found_v    = 1'b0;
      key_v      = BTN_DOWN;
      kind_v     = KIND_TOGGLE;
      slot_v     = 2'd0;
      has_slot_v = 1'b0;
      reached_v  = 1'b1;

      if (pressed_i == '0) begin
         // release path
         if (adj_v != ADJ_NONE) begin
            key_v          = (adj_v == ADJ_UP) ? BTN_UP : BTN_DOWN;
            adjevt_v       = adj_v;
            mode_v[key_v]  = MODE_IDLE;
            adj_v          = ADJ_NONE;
         end else if (cur_v < BTN_DOWN) begin
            kind_v = cfg_i.button_kinds[{cur_v, 1'b0} +: 2];
            unique case (mode_v[cur_v])
               MODE_HOLD: begin
                  if (kind_v == KIND_TOGHOLD) begin
                     mode_v[cur_v] = MODE_MOD;
                     snd_v         = SND_BEEP;
                  end else begin
                     mode_v[cur_v] = MODE_IDLE;
                     cur_v         = BTN_NONE;
                  end
               end
               MODE_WR_MOD: begin
                  mode_v[cur_v] = MODE_MOD;
                  snd_v         = SND_BEEP;
               end
               MODE_WR_PTM: begin
                  mode_v[cur_v] = MODE_PTM;
                  snd_v         = SND_BEEP;
               end
               MODE_WR_IDLE: begin
                  mode_v[cur_v] = (kind_v == KIND_MOMENT && cur_v == BTN_PLAT) ?
                                  MODE_DONE : MODE_IDLE;
                  snd_v         = SND_BEEP;
                  cur_v         = BTN_NONE;
               end
               MODE_MOD, MODE_PTM: begin
                  if (timeout_v) begin
                     mode_v[cur_v] = MODE_IDLE;
                     cur_v         = BTN_NONE;
                     snd_v         = SND_DOUBLE;
                  end
               end
               default: begin
                  flt_v         = 1'b1;
                  mode_v[cur_v] = MODE_IDLE;
                  cur_v         = BTN_NONE;
               end
            endcase
         end else begin
            // nothing active, so every mode should already be idle
            cur_v = BTN_NONE;
            if (mode_v != '0) begin
               flt_v  = 1'b1;
               mode_v = '0;
            end
         end
         if (!(&idle_v)) idle_v = idle_v + TICK_WIDTH'(1);
      end else begin
         idle_v = '0;
         // fixed priority, lowest index wins
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (!found_v && pressed_i[i]) begin
               found_v = 1'b1;
               b_v     = 4'(i);
            end
         end
         if (b_v <= BTN_PLAT) begin
            kind_v     = cfg_i.button_kinds[{b_v, 1'b0} +: 2];
            has_slot_v = (b_v == BTN_RATE) || (b_v == BTN_POWER) || (b_v == BTN_ALARM);
            slot_v     = (b_v == BTN_RATE) ? 2'd0 : ((b_v == BTN_POWER) ? 2'd1 : 2'd2);
            if ((power_state_i == PWR_ON || b_v == BTN_POWER || b_v == BTN_ALARM) &&
                (cur_v == b_v || cur_v >= BTN_DOWN) && adj_v == ADJ_NONE) begin
               unique case (mode_v[b_v])
                  MODE_IDLE: begin
                     unique case (kind_v)
                        KIND_HOLD, KIND_TOGHOLD: begin
                           mode_v[b_v] = MODE_HOLD;
                           if (b_v == BTN_RATE)
                              cnt_v[0] = TICK_WIDTH'(cfg_i.rate_hold_ticks);
                           else if (b_v == BTN_POWER)
                              cnt_v[1] = TICK_WIDTH'(cfg_i.power_hold_ticks);
                           else if (b_v == BTN_ALARM)
                              cnt_v[2] = TICK_WIDTH'(cfg_i.alarm_hold_ticks);
                        end
                        KIND_TOGGLE: mode_v[b_v] = MODE_WR_MOD;
                        default:     mode_v[b_v] = MODE_WR_IDLE;
                     endcase
                     cur_v = b_v;
                  end
                  MODE_HOLD: begin
                     if (has_slot_v) begin
                        if (cnt_v[slot_v] > TICK_WIDTH'(1)) begin
                           cnt_v[slot_v] = cnt_v[slot_v] - TICK_WIDTH'(1);
                           reached_v     = 1'b0;
                        end else begin
                           cnt_v[slot_v] = '0;
                        end
                     end
                     if (reached_v) begin
                        mode_v[b_v] = (kind_v == KIND_HOLD) ? MODE_WR_MOD : MODE_WR_PTM;
                        snd_v       = SND_BEEP;
                     end
                  end
                  MODE_MOD, MODE_PTM: mode_v[b_v] = MODE_WR_IDLE;
                  MODE_WR_MOD, MODE_WR_PTM, MODE_WR_IDLE: ;
                  default: flt_v = 1'b1;
               endcase
            end
         end else begin
            // adjust key, only while an editable button is modifying
            if (cur_v >= 4'd1 && cur_v <= 4'd5 &&
                (mode_v[cur_v] == MODE_MOD || mode_v[cur_v] == MODE_PTM) &&
                adj_v == ADJ_NONE) begin
               if (mode_v[b_v] == MODE_IDLE) begin
                  mode_v[b_v] = MODE_WR_IDLE;
                  adj_v       = (b_v == BTN_UP) ? ADJ_UP : ADJ_DOWN;
               end else if (mode_v[b_v] != MODE_WR_IDLE) begin
                  flt_v = 1'b1;
               end
            end
         end
      end

      unique case (mode_v[BTN_POWER])
         MODE_MOD: begin
            if (power_state_i == PWR_OFF) begin
               preq_v = PREQ_UP;
               snd_v  = SND_BEEP;
            end
            mode_v[BTN_POWER] = MODE_IDLE;
            cur_v             = BTN_NONE;
         end
         MODE_WR_PTM: begin
            if (power_state_i == PWR_ON) begin
               preq_v = PREQ_OFF;
               snd_v  = SND_TONE;
            end
            mode_v[BTN_POWER] = MODE_WR_IDLE;
         end
         MODE_DONE: flt_v = 1'b1;
         default: ;
      endcase

      unique case (mode_v[BTN_ALARM])
         MODE_MOD: begin
            alarm_v           = ALARM_MUTE;
            mode_v[BTN_ALARM] = MODE_IDLE;
            cur_v             = BTN_NONE;
         end
         MODE_WR_PTM: begin
            alarm_v           = ALARM_WIPE;
            mode_v[BTN_ALARM] = MODE_WR_IDLE;
         end
         MODE_DONE: flt_v = 1'b1;
         default: ;
      endcase

      if (mode_v[BTN_PLAT] == MODE_DONE) begin
         plat_v           = 1'b1;
         mode_v[BTN_PLAT] = MODE_IDLE;
      end

      if (cur_v >= BTN_DOWN) cur_v = BTN_NONE;

      rsp_o.sound_cue       = snd_v;
      rsp_o.power_request   = preq_v;
      rsp_o.alarm_action    = alarm_v;
      rsp_o.plateau_request = plat_v;
      rsp_o.adjust_event    = adjevt_v;
      rsp_o.active_button   = cur_v;
      rsp_o.active_mode     = (cur_v == BTN_NONE) ? MODE_IDLE : mode_v[cur_v];
      rsp_o.fault           = flt_v;

      mode_o    = mode_v;
      count_o   = cnt_v;
      cur_btn_o = cur_v;
      cur_adj_o = adj_v;
      idle_o    = idle_v;
   end

endmodule

// File: src/panel_button_mode_controller.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_ready  req_pressed_buttons, req_power_state
// rsp       out        rsp_valid/rsp_ready  rsp_sound_cue .. rsp_fault (one per transaction)
// csr       in         psel/penable/pwrite  paddr, pwdata, prdata, pready (always high)
//
// one transaction per cycle sustained while rsp is not stalled; a req reaches rsp valid through
// the input register, one pass of the step logic and the result register
// reset clears all button modes, countdowns and the idle counter and loads the registers with their defaults
// a stalled rsp holds its result while one more transaction waits in the input register
module panel_button_mode_controller #(
   parameter int TICK_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [pbmc_pkg::NUM_BUTTONS-1:0] req_pressed_buttons,
   input  logic [1:0]                       req_power_state,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_sound_cue,
   output logic [1:0]                       rsp_power_request,
   output logic [1:0]                       rsp_alarm_action,
   output logic                             rsp_plateau_request,
   output logic [1:0]                       rsp_adjust_event,
   output logic [3:0]                       rsp_active_button,
   output logic [2:0]                       rsp_active_mode,
   output logic                             rsp_fault,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [4:0]                       paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import pbmc_pkg::*;

   cfg_type                    cfg_ff;
   logic                       in_valid_ff;
   logic [NUM_BUTTONS-1:0]     in_pressed_ff;
   logic [1:0]                 in_power_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_ff;
   rsp_type                    rsp_in;
   mode_vec_type               mode_ff;
   mode_vec_type               mode_in;
   logic [2:0][TICK_WIDTH-1:0] count_ff;
   logic [2:0][TICK_WIDTH-1:0] count_in;
   logic [3:0]                 cur_btn_ff;
   logic [3:0]                 cur_btn_in;
   logic [1:0]                 cur_adj_ff;
   logic [1:0]                 cur_adj_in;
   logic [TICK_WIDTH-1:0]      idle_ff;
   logic [TICK_WIDTH-1:0]      idle_in;
   logic                       advance;
   logic                       csr_write;
   logic [2:0]                 reg_index;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_index = paddr[4:2];

   pbmc_step #(.TICK_WIDTH(TICK_WIDTH)) u_step (
      .pressed_i     (in_pressed_ff),
      .power_state_i (in_power_ff),
      .cfg_i         (cfg_ff),
      .mode_i        (mode_ff),
      .count_i       (count_ff),
      .cur_btn_i     (cur_btn_ff),
      .cur_adj_i     (cur_adj_ff),
      .idle_i        (idle_ff),
      .mode_o        (mode_in),
      .count_o       (count_in),
      .cur_btn_o     (cur_btn_in),
      .cur_adj_o     (cur_adj_in),
      .idle_o        (idle_in),
      .rsp_o         (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.button_kinds       <= RST_BUTTON_KINDS;
         cfg_ff.rate_hold_ticks    <= RST_RATE_HOLD;
         cfg_ff.power_hold_ticks   <= RST_POWER_HOLD;
         cfg_ff.alarm_hold_ticks   <= RST_ALARM_HOLD;
         cfg_ff.edit_timeout_ticks <= RST_EDIT_TIMEOUT;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_BUTTON_KINDS: cfg_ff.button_kinds       <= pwdata[21:0];
            REG_RATE_HOLD:    cfg_ff.rate_hold_ticks    <= pwdata[15:0];
            REG_POWER_HOLD:   cfg_ff.power_hold_ticks   <= pwdata[15:0];
            REG_ALARM_HOLD:   cfg_ff.alarm_hold_ticks   <= pwdata[15:0];
            REG_EDIT_TIMEOUT: cfg_ff.edit_timeout_ticks <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_BUTTON_KINDS: prdata = {10'd0, cfg_ff.button_kinds};
         REG_RATE_HOLD:    prdata = {16'd0, cfg_ff.rate_hold_ticks};
         REG_POWER_HOLD:   prdata = {16'd0, cfg_ff.power_hold_ticks};
         REG_ALARM_HOLD:   prdata = {16'd0, cfg_ff.alarm_hold_ticks};
         REG_EDIT_TIMEOUT: prdata = {16'd0, cfg_ff.edit_timeout_ticks};
         default:          prdata = 32'd0;
      endcase
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_pressed_ff <= req_pressed_buttons;
         in_power_ff   <= req_power_state;
      end
   end

   // button state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= '0;
         count_ff     <= '0;
         cur_btn_ff   <= BTN_NONE;
         cur_adj_ff   <= ADJ_NONE;
         idle_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         cur_btn_ff   <= cur_btn_in;
         cur_adj_ff   <= cur_adj_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sound_cue       = rsp_ff.sound_cue;
   assign rsp_power_request   = rsp_ff.power_request;
   assign rsp_alarm_action    = rsp_ff.alarm_action;
   assign rsp_plateau_request = rsp_ff.plateau_request;
   assign rsp_adjust_event    = rsp_ff.adjust_event;
   assign rsp_active_button   = rsp_ff.active_button;
   assign rsp_active_mode     = rsp_ff.active_mode;
   assign rsp_fault           = rsp_ff.fault;

   // an open adjust key always sits in wait-for-release
   a_adj_up_mode: assert property (@(posedge clock) disable iff (reset)
      (cur_adj_ff == ADJ_UP) |-> (mode_ff[BTN_UP] == MODE_WR_IDLE))
      else $error("adjust up open without its key waiting for release");

   a_adj_down_mode: assert property (@(posedge clock) disable iff (reset)
      (cur_adj_ff == ADJ_DOWN) |-> (mode_ff[BTN_DOWN] == MODE_WR_IDLE))
      else $error("adjust down open without its key waiting for release");

   a_active_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.active_button <= BTN_PLAT ||
                        rsp_ff.active_button == BTN_NONE))
      else $error("active button out of range");

   a_none_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.active_button == BTN_NONE) |-> (rsp_ff.active_mode == MODE_IDLE))
      else $error("mode reported with no active button");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("result changed while stalled");

endmodule

// File: verif/tb_panel_button_mode_controller.sv
`timescale 1ns / 1ps

module tb_panel_button_mode_controller;
   import pbmc_pkg::*;

   localparam logic [1:0] PWR_RISING = 2'd1;
   localparam logic [1:0] PWR_BAD    = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_HOLD_CYCLES = 150;

   typedef struct packed {
      logic [NUM_BUTTONS-1:0] mask;
      logic [1:0]             pstate;
   } scan_item_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [NUM_BUTTONS-1:0] req_pressed_buttons = '0;
   logic [1:0]             req_power_state = PWR_OFF;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_sound_cue;
   logic [1:0]             rsp_power_request;
   logic [1:0]             rsp_alarm_action;
   logic                   rsp_plateau_request;
   logic [1:0]             rsp_adjust_event;
   logic [3:0]             rsp_active_button;
   logic [2:0]             rsp_active_mode;
   logic                   rsp_fault;
   logic                   psel = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite = 1'b0;
   logic [4:0]             paddr = '0;
   logic [31:0]            pwdata = '0;
   logic [31:0]            prdata;
   logic                   pready;

   // predictor state
   cfg_type    cfg;
   logic [2:0] btn_mode [NUM_BUTTONS];
   logic [15:0] hold_left [3];
   logic [3:0] active_btn;
   logic [1:0] active_adj;
   logic [15:0] idle_count;

   scan_item_type scan_q [$];
   rsp_type       expected_q [$];

   int  mismatches = 0;
   int  results_seen = 0;
   int  quiet_cycles = 0;
   bit  req_taken = 1'b0;
   bit  calm = 1'b0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_asks = 0;
   int  hold_seen = 0;
   int  drain_hold = 0;

   panel_button_mode_controller dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_pressed_buttons (req_pressed_buttons),
      .req_power_state     (req_power_state),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sound_cue       (rsp_sound_cue),
      .rsp_power_request   (rsp_power_request),
      .rsp_alarm_action    (rsp_alarm_action),
      .rsp_plateau_request (rsp_plateau_request),
      .rsp_adjust_event    (rsp_adjust_event),
      .rsp_active_button   (rsp_active_button),
      .rsp_active_mode     (rsp_active_mode),
      .rsp_fault           (rsp_fault),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one scan tick of the button controller, updates the predictor state
   function automatic rsp_type scan_tick(input logic [NUM_BUTTONS-1:0] mask,
                                         input logic [1:0] pstate);
      rsp_type    r;
      logic [3:0] b;
      logic [3:0] c;
      logic [1:0] kind;
      int         slot;
      logic       reached;
      r = '0;
      if (mask == '0) begin
         if (active_adj != ADJ_NONE) begin
            r.adjust_event = active_adj;
            btn_mode[(active_adj == ADJ_UP) ? BTN_UP : BTN_DOWN] = MODE_IDLE;
            active_adj = ADJ_NONE;
         end else if (active_btn < BTN_DOWN) begin
            c = active_btn;
            kind = cfg.button_kinds[2*c +: 2];
            case (btn_mode[c])
               MODE_HOLD: begin
                  if (kind == KIND_TOGHOLD) begin
                     btn_mode[c] = MODE_MOD;
                     r.sound_cue = SND_BEEP;
                  end else begin
                     btn_mode[c] = MODE_IDLE;
                     active_btn = BTN_NONE;
                  end
               end
               MODE_WR_MOD: begin
                  btn_mode[c] = MODE_MOD;
                  r.sound_cue = SND_BEEP;
               end
               MODE_WR_PTM: begin
                  btn_mode[c] = MODE_PTM;
                  r.sound_cue = SND_BEEP;
               end
               MODE_WR_IDLE: begin
                  btn_mode[c] = (kind == KIND_MOMENT && c == BTN_PLAT) ? MODE_DONE : MODE_IDLE;
                  r.sound_cue = SND_BEEP;
                  active_btn = BTN_NONE;
               end
               MODE_MOD, MODE_PTM: begin
                  if (idle_count >= cfg.edit_timeout_ticks) begin
                     btn_mode[c] = MODE_IDLE;
                     active_btn = BTN_NONE;
                     r.sound_cue = SND_DOUBLE;
                  end
               end
               default: begin
                  r.fault = 1'b1;
                  btn_mode[c] = MODE_IDLE;
                  active_btn = BTN_NONE;
               end
            endcase
         end else begin
            // nothing active: any leftover mode is a fault and everything resets
            active_btn = BTN_NONE;
            for (int i = 0; i < NUM_BUTTONS; i++)
               if (btn_mode[i] != MODE_IDLE) r.fault = 1'b1;
            if (r.fault)
               for (int i = 0; i < NUM_BUTTONS; i++) btn_mode[i] = MODE_IDLE;
         end
         if (idle_count != '1) idle_count++;
      end else begin
         idle_count = '0;
         b = '0;
         while (!mask[b]) b++;
         if (b <= BTN_PLAT) begin
            if ((pstate == PWR_ON || b == BTN_POWER || b == BTN_ALARM) &&
                (active_btn == b || active_btn >= BTN_DOWN) && active_adj == ADJ_NONE) begin
               slot = -1;
               if (b == BTN_RATE) slot = 0;
               else if (b == BTN_POWER) slot = 1;
               else if (b == BTN_ALARM) slot = 2;
               kind = cfg.button_kinds[2*b +: 2];
               case (btn_mode[b])
                  MODE_IDLE: begin
                     case (kind)
                        KIND_HOLD, KIND_TOGHOLD: begin
                           btn_mode[b] = MODE_HOLD;
                           case (slot)
                              0: hold_left[0] = cfg.rate_hold_ticks;
                              1: hold_left[1] = cfg.power_hold_ticks;
                              2: hold_left[2] = cfg.alarm_hold_ticks;
                              default: ;
                           endcase
                        end
                        KIND_TOGGLE: btn_mode[b] = MODE_WR_MOD;
                        default: btn_mode[b] = MODE_WR_IDLE;
                     endcase
                     active_btn = b;
                  end
                  MODE_HOLD: begin
                     reached = 1'b1;
                     if (slot >= 0) begin
                        if (hold_left[slot] > 16'd1) begin
                           hold_left[slot]--;
                           reached = 1'b0;
                        end else begin
                           hold_left[slot] = '0;
                        end
                     end
                     if (reached) begin
                        btn_mode[b] = (kind == KIND_HOLD) ? MODE_WR_MOD : MODE_WR_PTM;
                        r.sound_cue = SND_BEEP;
                     end
                  end
                  MODE_MOD, MODE_PTM: btn_mode[b] = MODE_WR_IDLE;
                  MODE_WR_MOD, MODE_WR_PTM, MODE_WR_IDLE: ;
                  default: r.fault = 1'b1;
               endcase
            end
         end else if (active_btn >= 4'd1 && active_btn <= 4'd5 &&
                      (btn_mode[active_btn] == MODE_MOD || btn_mode[active_btn] == MODE_PTM) &&
                      active_adj == ADJ_NONE) begin
            if (btn_mode[b] == MODE_IDLE) begin
               btn_mode[b] = MODE_WR_IDLE;
               active_adj = (b == BTN_UP) ? ADJ_UP : ADJ_DOWN;
            end else if (btn_mode[b] != MODE_WR_IDLE) begin
               r.fault = 1'b1;
            end
         end
      end

      case (btn_mode[BTN_POWER])
         MODE_MOD: begin
            if (pstate == PWR_OFF) begin
               r.power_request = PREQ_UP;
               r.sound_cue = SND_BEEP;
            end
            btn_mode[BTN_POWER] = MODE_IDLE;
            active_btn = BTN_NONE;
         end
         MODE_WR_PTM: begin
            if (pstate == PWR_ON) begin
               r.power_request = PREQ_OFF;
               r.sound_cue = SND_TONE;
            end
            btn_mode[BTN_POWER] = MODE_WR_IDLE;
         end
         MODE_DONE: r.fault = 1'b1;
         default: ;
      endcase

      case (btn_mode[BTN_ALARM])
         MODE_MOD: begin
            r.alarm_action = ALARM_MUTE;
            btn_mode[BTN_ALARM] = MODE_IDLE;
            active_btn = BTN_NONE;
         end
         MODE_WR_PTM: begin
            r.alarm_action = ALARM_WIPE;
            btn_mode[BTN_ALARM] = MODE_WR_IDLE;
         end
         MODE_DONE: r.fault = 1'b1;
         default: ;
      endcase

      if (btn_mode[BTN_PLAT] == MODE_DONE) begin
         r.plateau_request = 1'b1;
         btn_mode[BTN_PLAT] = MODE_IDLE;
      end

      if (active_btn >= BTN_DOWN) begin
         active_btn = BTN_NONE;
         r.active_button = BTN_NONE;
         r.active_mode = MODE_IDLE;
      end else begin
         r.active_button = active_btn;
         r.active_mode = btn_mode[active_btn];
      end
      return r;
   endfunction

   function automatic string rsp_text(input rsp_type r);
      return $sformatf("snd=%0d preq=%0d alarm=%0d plat=%0d adj=%0d btn=%0d mode=%0d fault=%0d",
                       r.sound_cue, r.power_request, r.alarm_action, r.plateau_request,
                       r.adjust_event, r.active_button, r.active_mode, r.fault);
   endfunction

   // a pressed button, sometimes with lower-priority buttons held as well
   function automatic logic [NUM_BUTTONS-1:0] press_mask(input int b);
      logic [NUM_BUTTONS-1:0] extra;
      extra = '0;
      if ($urandom_range(0, 3) == 0)
         extra = NUM_BUTTONS'($urandom) & ~NUM_BUTTONS'((2 << b) - 1);
      return (NUM_BUTTONS'(1) << b) | extra;
   endfunction

   function automatic logic [1:0] pick_power();
      return ($urandom_range(0, 5) != 0) ? PWR_ON : 2'($urandom_range(0, 3));
   endfunction

   task automatic push_scan(input logic [NUM_BUTTONS-1:0] mask, input logic [1:0] pstate,
                            input int reps);
      scan_item_type it;
      it.mask = mask;
      it.pstate = pstate;
      repeat (reps) scan_q.push_back(it);
   endtask

   // mostly well-formed press / hold / release and edit sessions, some noise
   task automatic queue_scans(input int count);
      int         start;
      int         cap;
      int         tmo_span;
      int         b;
      logic [1:0] ps;
      start = scan_q.size();
      cap = int'(cfg.rate_hold_ticks);
      if (int'(cfg.power_hold_ticks) > cap) cap = int'(cfg.power_hold_ticks);
      if (int'(cfg.alarm_hold_ticks) > cap) cap = int'(cfg.alarm_hold_ticks);
      cap = (cap > 38) ? 40 : cap + 2;
      tmo_span = (cfg.edit_timeout_ticks > 16'd30) ? 6 : int'(cfg.edit_timeout_ticks) + 2;
      while (scan_q.size() - start < count) begin
         ps = pick_power();
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               b = $urandom_range(0, 8);
               push_scan(press_mask(b), ps, $urandom_range(1, cap));
               push_scan('0, ps, $urandom_range(1, 3));
            end
            4, 5, 6: begin
               b = $urandom_range(0, 5);
               push_scan(press_mask(b), ps, $urandom_range(1, 2));
               push_scan('0, ps, $urandom_range(1, 2));
               repeat ($urandom_range(1, 4)) begin
                  push_scan(NUM_BUTTONS'($urandom_range(1, 3)) << BTN_DOWN, ps,
                            $urandom_range(1, 3));
                  push_scan('0, ps, $urandom_range(1, 2));
               end
               if ($urandom_range(0, 1) == 0) begin
                  push_scan(press_mask(b), ps, $urandom_range(1, 2));
                  push_scan('0, ps, $urandom_range(1, 2));
               end else begin
                  push_scan('0, ps, $urandom_range(1, tmo_span));
               end
            end
            7: begin
               repeat ($urandom_range(1, 4))
                  push_scan(NUM_BUTTONS'($urandom), 2'($urandom_range(0, 3)), 1);
            end
            default: begin
               b = int'(BTN_POWER) + $urandom_range(0, 2);
               push_scan(press_mask(b), 2'($urandom_range(0, 3)), $urandom_range(1, cap));
               push_scan('0, 2'($urandom_range(0, 3)), $urandom_range(1, 3));
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      while (scan_q.size() != 0 || req_valid || expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] wmask;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      readback = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_BUTTON_KINDS: cfg.button_kinds = value[21:0];
         REG_RATE_HOLD:    cfg.rate_hold_ticks = value[15:0];
         REG_POWER_HOLD:   cfg.power_hold_ticks = value[15:0];
         REG_ALARM_HOLD:   cfg.alarm_hold_ticks = value[15:0];
         REG_EDIT_TIMEOUT: cfg.edit_timeout_ticks = value[15:0];
         default: ;
      endcase
      wmask = (idx == REG_BUTTON_KINDS) ? 32'h003F_FFFF : 32'h0000_FFFF;
      if (readback !== (value & wmask)) begin
         if (mismatches < 10)
            $display("csr readback mismatch reg %0d: expected %h, got %h",
                     idx, value & wmask, readback);
         mismatches++;
      end
   endtask

   task automatic apply_settings(input logic [21:0] kinds, input logic [15:0] rate,
                                 input logic [15:0] power, input logic [15:0] alarm,
                                 input logic [15:0] timeout);
      csr_write(REG_BUTTON_KINDS, 32'(kinds));
      csr_write(REG_RATE_HOLD, 32'(rate));
      csr_write(REG_POWER_HOLD, 32'(power));
      csr_write(REG_ALARM_HOLD, 32'(alarm));
      csr_write(REG_EDIT_TIMEOUT, 32'(timeout));
   endtask

   // sender
   always @(negedge clock) begin : sender
      scan_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // transaction still pending, hold it
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         send_gap = $urandom_range(0, 7);
         req_valid <= 1'b0;
      end else if (scan_q.size() > 0) begin
         it = scan_q.pop_front();
         req_pressed_buttons <= it.mask;
         req_power_state <= it.pstate;
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver
   always @(negedge clock) begin : receiver
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         drain_hold = DRAIN_HOLD_CYCLES;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (drain_hold > 0) begin
         drain_hold--;
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         recv_gap = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin : monitor
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_sound_cue, rsp_power_request, rsp_alarm_action, rsp_plateau_request,
                    rsp_adjust_event, rsp_active_button, rsp_active_mode, rsp_fault};
            if (expected_q.size() == 0) begin
               if (mismatches < 10)
                  $display("result %0d with nothing expected: %s", results_seen, rsp_text(seen));
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               if (seen !== want) begin
                  if (mismatches < 10) begin
                     $display("result %0d mismatch", results_seen);
                     $display("  expected %s", rsp_text(want));
                     $display("  actual   %s", rsp_text(seen));
                  end
                  mismatches++;
               end
            end
            results_seen++;
         end
         if (req_taken)
            expected_q.push_back(scan_tick(req_pressed_buttons, req_power_state));
         if (req_taken || (rsp_valid && rsp_ready) || psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin : watchdog
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : main
      cfg = {RST_BUTTON_KINDS, RST_RATE_HOLD, RST_POWER_HOLD, RST_ALARM_HOLD, RST_EDIT_TIMEOUT};
      for (int i = 0; i < NUM_BUTTONS; i++) btn_mode[i] = MODE_IDLE;
      for (int i = 0; i < 3; i++) hold_left[i] = '0;
      active_btn = BTN_NONE;
      active_adj = ADJ_NONE;
      idle_count = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed pass on reset settings
      push_scan('0, PWR_ON, 1);
      push_scan(NUM_BUTTONS'(1) << 1, PWR_ON, 1);
      push_scan('0, PWR_ON, 1);
      push_scan(NUM_BUTTONS'(1) << BTN_UP, PWR_ON, 1);
      // second adjust key while one is busy is ignored
      push_scan((NUM_BUTTONS'(1) << BTN_UP) | (NUM_BUTTONS'(1) << BTN_DOWN), PWR_ON, 1);
      push_scan('0, PWR_ON, 1);
      push_scan(NUM_BUTTONS'(1) << BTN_DOWN, PWR_ON, 1);
      push_scan('0, PWR_ON, 1);
      push_scan(NUM_BUTTONS'(1) << 1, PWR_ON, 1);
      push_scan('0, PWR_ON, 1);
      push_scan(NUM_BUTTONS'(1) << BTN_PLAT, PWR_ON, 1);
      push_scan('0, PWR_ON, 1);
      // power and alarm work with power off or in an odd state
      push_scan(NUM_BUTTONS'(1) << BTN_POWER, PWR_OFF, 1);
      push_scan('0, PWR_OFF, 1);
      push_scan(NUM_BUTTONS'(1) << BTN_ALARM, PWR_BAD, 1);
      push_scan('0, PWR_BAD, 1);
      push_scan('1, PWR_ON, 1);
      push_scan('0, PWR_ON, 1);
      push_scan(NUM_BUTTONS'(1), PWR_ON, 1);
      push_scan('0, PWR_ON, 1);
      push_scan(NUM_BUTTONS'(1) << 2, PWR_RISING, 1);
      push_scan(NUM_BUTTONS'(11'h7FE), PWR_BAD, 1);
      push_scan('0, PWR_ON, 1);
      wait_drained();

      apply_settings(22'($urandom), 16'd3, 16'd4, 16'd2, 16'd6);
      queue_scans(200);
      wait_drained();

      apply_settings(22'h000000, 16'd1, 16'd1, 16'd1, 16'd1);
      queue_scans(100);
      wait_drained();

      // zero hold length behaves as one tick
      apply_settings(22'h3FFFFF, 16'd0, 16'd2, 16'd5, 16'hFFFF);
      queue_scans(120);
      wait_drained();

      apply_settings(22'($urandom), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd4);
      queue_scans(100);
      wait_drained();

      apply_settings(22'($urandom), 16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                     16'($urandom_range(1, 8)), 16'($urandom_range(2, 12)));
      queue_scans(180);
      // long receiver stall while the sender keeps offering
      hold_asks++;
      wait_drained();

      calm = 1'b1;
      apply_settings(RST_BUTTON_KINDS, RST_RATE_HOLD, RST_POWER_HOLD, RST_ALARM_HOLD,
                     RST_EDIT_TIMEOUT);
      queue_scans(150);
      wait_drained();
      repeat (10) @(posedge clock);

      if (mismatches == 0 && expected_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: panel_button_mode_controller.f
src/pbmc_pkg.sv
src/pbmc_step.sv
src/panel_button_mode_controller.sv
verif/tb_panel_button_mode_controller.sv
